/* rtl/core/fds_pkg.sv */
// Package for the foci distance sum unit.
// Shared constants, types and the square root step function; no dependencies.
package fds_pkg;
	localparam int FOCI_DEF = 4;
	localparam int COORD_BITS_DEF = 16;
	localparam int FOCUS_REGS = 4;
	localparam int FOCUS_W = 32;
	localparam int IDX_W = 2;
	localparam int SUM_W = 19;
	localparam int SQ_W = 33;
	localparam int ROOT_W = 17;
	localparam int ROOT_STEPS = 17;

	typedef logic [FOCUS_W-1:0] focus_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	// One restoring step of the digit-by-digit square root for result bit k.
	function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int k);
		sqrt_state_t r;
		logic [SQ_W+1:0] trial;
		r = s;
		trial = ({2'b00, SQ_W'(s.root)} << (k + 1)) | ((SQ_W + 2)'(1) << (2 * k));
		if ({2'b00, s.rem} >= trial) begin
			r.rem = SQ_W'({2'b00, s.rem} - trial);
			r.root = s.root | (ROOT_W'(1) << k);
		end
		return r;
	endfunction
endpackage

/* rtl/core/fds_cell.sv */
// One root cell of the chain: resolves one bit of every focus square root.
// Depends on fds_pkg.
module fds_cell #(
	parameter int FOCI = fds_pkg::FOCI_DEF,
	parameter int BIT = 0
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic vld_in,
	input fds_pkg::sqrt_state_t st_in [FOCI],
	output logic vld_out,
	output fds_pkg::sqrt_state_t st_out [FOCI]
);
	import fds_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int f = 0; f < FOCI; f++) begin
				st_out[f] <= sqrt_step(st_in[f], BIT);
			end
		end
	end
endmodule

/* rtl/core/foci_distance_sum_unit.sv */
// Top level of the foci distance sum unit.
// Depends on fds_pkg and fds_cell.
//
// Usage: a point enters on the input channel (valid/ready, point_x, point_y)
// and one transaction leaves on the output channel carrying distance_sum, the
// sum over foci of the floor square root of the squared distance.
// Foci are written through cfg_we, cfg_idx, cfg_data while the unit is idle;
// indexes above three are ignored.
// Stage one forms differences, stage two squares and adds them, then a chain
// of 17 root cells resolves one root bit each, and a final stage adds the
// roots into the registered distance_sum.
// Throughput is one point per cycle while the output is not stalled: all stages advance together.
// When the receiver stalls, the whole chain holds and in_ready falls;
// the chain length sets the latency.
// Reset clears all focus registers to zero and empties the chain.
module foci_distance_sum_unit #(
	parameter int FOCI = fds_pkg::FOCI_DEF,
	parameter int COORD_BITS = fds_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [fds_pkg::IDX_W:0] cfg_idx,
	input logic [fds_pkg::FOCUS_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] point_x,
	input logic [15:0] point_y,
	output logic out_valid,
	input logic out_ready,
	output logic [fds_pkg::SUM_W-1:0] distance_sum
);
	import fds_pkg::*;

	localparam int CB = COORD_BITS;

	focus_t focus_q [FOCUS_REGS];
	logic adv;
	logic vld_s1, vld_s2;
	logic [CB-1:0] dx_s1 [FOCI];
	logic [CB-1:0] dy_s1 [FOCI];
	sqrt_state_t st [ROOT_STEPS+1][FOCI];
	logic vld [ROOT_STEPS+1];

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FOCUS_REGS; i++) focus_q[i] <= '0;
		end else if (cfg_we && cfg_idx < (IDX_W + 1)'(FOCUS_REGS)) begin
			focus_q[cfg_idx[IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			out_valid <= vld[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int f = 0; f < FOCI; f++) begin
				dx_s1[f] <= (focus_q[f][CB-1:0] >= point_x[CB-1:0]) ?
					focus_q[f][CB-1:0] - point_x[CB-1:0] :
					point_x[CB-1:0] - focus_q[f][CB-1:0];
				dy_s1[f] <= (focus_q[f][16+CB-1:16] >= point_y[CB-1:0]) ?
					focus_q[f][16+CB-1:16] - point_y[CB-1:0] :
					point_y[CB-1:0] - focus_q[f][16+CB-1:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int f = 0; f < FOCI; f++) begin
				st[0][f].rem <= SQ_W'(dx_s1[f]) * SQ_W'(dx_s1[f])
					+ SQ_W'(dy_s1[f]) * SQ_W'(dy_s1[f]);
				st[0][f].root <= '0;
			end
		end
	end
	assign vld[0] = vld_s2;

	for (genvar c = 0; c < ROOT_STEPS; c++) begin : g_cell
		fds_cell #(.FOCI(FOCI), .BIT(ROOT_STEPS - 1 - c)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.vld_in(vld[c]),
			.st_in(st[c]),
			.vld_out(vld[c+1]),
			.st_out(st[c+1])
		);
	end

	logic [SUM_W-1:0] total;
	always_comb begin
		total = '0;
		for (int f = 0; f < FOCI; f++) total = total + SUM_W'(st[ROOT_STEPS][f].root);
	end

	always_ff @(posedge clk) begin
		if (adv) distance_sum <= total;
	end
endmodule

/* rtl/core/fds_checker.sv */
// Port-level checker for the foci distance sum unit, bound to the top level.
// Depends on foci_distance_sum_unit.
module fds_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [18:0] distance_sum
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_sum))
		else $error("output transaction changed while stalled");
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_sum <= 19'd370720)
		else $error("distance sum out of range");
endmodule

bind foci_distance_sum_unit fds_checker u_fds_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.distance_sum(distance_sum)
);

/* tb/sv/tb_foci_distance_sum_unit.sv */
// Testbench for foci_distance_sum_unit: directed table plus random points, checked
// against a behavioral distance-sum predictor with a queue of expected sums.
// Depends on fds_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_foci_distance_sum_unit;
	import fds_pkg::*;

	localparam int FOCI = FOCI_DEF;
	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int LATENCY = 19;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1530;
	localparam int ROWS = 12;
	localparam logic [18:0] NO_SUM = '1;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [18:0] sum;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W:0] cfg_idx = '0;
	logic [FOCUS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] point_x = '0;
	logic [15:0] point_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SUM_W-1:0] distance_sum;

	focus_t focus_model [FOCUS_REGS];
	logic [SUM_W-1:0] sum_queue [$];
	logic [SUM_W-1:0] typed_queue [$];
	point_row_t rows [ROWS];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	foci_distance_sum_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [39:0] floor_root(logic [39:0] v);
		logic [39:0] root;
		logic [39:0] probe;
		root = '0;
		for (int b = 19; b >= 0; b--) begin
			probe = root | (40'd1 << b);
			if (probe * probe <= v) begin
				root = probe;
			end
		end
		return root;
	endfunction

	function automatic logic [SUM_W-1:0] predict_sum(logic [15:0] px, logic [15:0] py);
		logic [15:0] mask;
		logic [39:0] total;
		logic [39:0] dx;
		logic [39:0] dy;
		mask = 16'((32'd1 << COORD_BITS) - 1);
		total = '0;
		for (int i = 0; i < FOCI && i < FOCUS_REGS; i++) begin
			dx = 40'(focus_model[i][15:0] & mask) - 40'(px & mask);
			dy = 40'(focus_model[i][31:16] & mask) - 40'(py & mask);
			if (dx[39]) dx = -dx;
			if (dy[39]) dy = -dy;
			total += floor_root(dx * dx + dy * dy);
		end
		return total[SUM_W-1:0];
	endfunction

	task automatic write_focus(int idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= (IDX_W + 1)'(idx);
		cfg_data <= value;
		if (idx < FOCUS_REGS) focus_model[idx] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sum_queue.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_point(logic [15:0] x, logic [15:0] y, logic [18:0] typed);
		point_x <= x;
		point_y <= y;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sum_queue.push_back(predict_sum(x, y));
		typed_queue.push_back(typed);
		@(negedge clk);
	endtask

	task automatic send_random(int count, bit corner);
		int burst;
		int gap;
		logic [15:0] x;
		logic [15:0] y;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 3) * $urandom_range(0, 1);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst = $urandom_range(1, 30);
			end
			x = 16'($urandom);
			y = 16'($urandom);
			if (corner && $urandom_range(0, 3) == 0) x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			if (corner && $urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			send_point(x, y, NO_SUM);
			burst--;
		end
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		logic [SUM_W-1:0] want;
		logic [SUM_W-1:0] typed;
		if (arst_n && out_valid && out_ready) begin
			if (sum_queue.size() == 0) begin
				$display("%0t: unexpected transaction, actual %0d", $time, distance_sum);
				errors++;
			end else begin
				want = sum_queue.pop_front();
				typed = typed_queue.pop_front();
				if (distance_sum !== want) begin
					$display("%0t: distance_sum expected %0d actual %0d", $time, want,
						distance_sum);
					errors++;
				end
				if (typed != NO_SUM && distance_sum !== typed) begin
					$display("%0t: table sum expected %0d actual %0d", $time, typed,
						distance_sum);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		int phase;
		phase = $urandom_range(0, 15);
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($time / 400) % 3 == 0 ? 1'b1 : (phase > 4);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		rows = '{
			'{16'h0000, 16'h0000, 19'd0},
			'{16'hFFFF, 16'hFFFF, 19'd370720},
			'{16'hFFFF, 16'h0000, 19'd262140},
			'{16'h0000, 16'hFFFF, 19'd262140},
			'{16'h0003, 16'h0004, 19'd20},
			'{16'h5555, 16'hAAAA, NO_SUM},
			'{16'hAAAA, 16'h5555, NO_SUM},
			'{16'h0001, 16'h0001, NO_SUM},
			'{16'h8000, 16'h8000, NO_SUM},
			'{16'h7FFF, 16'h0001, NO_SUM},
			'{16'h1234, 16'hFEDC, NO_SUM},
			'{16'hFFFE, 16'h7FFF, NO_SUM}
		};
		foreach (focus_model[i]) focus_model[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[r]) send_point(rows[r].x, rows[r].y, rows[r].sum);
		in_valid <= 1'b0;
		drain();

		write_focus(0, 32'hFFFF_FFFF);
		write_focus(1, 32'h0000_0000);
		write_focus(2, 32'hFFFF_0000);
		write_focus(3, 32'h0000_FFFF);
		write_focus(4, 32'h1234_5678);
		write_focus(7, 32'hDEAD_BEEF);
		send_point(16'hFFFF, 16'hFFFF, NO_SUM);
		send_point(16'h0000, 16'hFFFF, NO_SUM);
		send_point(16'h8000, 16'h8000, NO_SUM);
		in_valid <= 1'b0;
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			for (int i = 0; i < FOCUS_REGS; i++) write_focus(i, $urandom);
			if (phase == 1) begin
				write_focus(2, 32'hFFFF_FFFF);
				write_focus(3, 32'h0000_0000);
			end
			if (phase == 2) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (120) @(negedge clk);
						hold_off = 1'b0;
					end
					send_random(60, 1'b1);
				join
			end
			send_random(RANDOM_ITEMS / 5 - (phase == 2 ? 60 : 0), phase != 3);
			drain();
		end

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/core/fds_pkg.sv
rtl/core/fds_cell.sv
rtl/core/foci_distance_sum_unit.sv
rtl/core/fds_checker.sv
tb/sv/tb_foci_distance_sum_unit.sv
